>>> hdl/tet_pkg.sv
package tet_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 48;

	typedef enum logic [1:0] {
		REQ_SCHED   = 2'd0,
		REQ_CANCEL  = 2'd1,
		REQ_SETWAIT = 2'd2,
		REQ_TICK    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_SCHEDULED = 3'd0,
		ST_FULL      = 3'd1,
		ST_FIRED     = 3'd2,
		ST_IDLE_TICK = 3'd3,
		ST_ACCEPTED  = 3'd4,
		ST_NOT_LIVE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PRIME,
		S_SCAN,
		S_FLUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request, clear scan index
		logic exec;   // carry out a non-tick request
		logic eval;   // evaluate scanned slot
		logic flush;  // emit final tick result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;   // request at the input is a tick
		logic out_free;  // output register can take a transfer now
		logic need_out;  // evaluating this slot emits a result
		logic scan_end;  // scan index is at the last slot
	} sts_t;

endpackage

>>> hdl/timed_event_table_core.sv
// Schedule, cancel and set-wait are captured in the request registers; their result then
// goes to the output register. A tick primes the read of the slot RAMs, scans each slot in
// turn and ends with a flush; a fired slot's result leaves one firing later, the last one
// at the flush. The block takes no new request until the current one is done, and the
// scan walks the slot RAMs through a single read port; output stalls hold the block.
// Reset (arst_n, async): all slots free and not cancelled, no result pending, no clearing pass.
module timed_event_table_core #(
	parameter int SLOTS     = tet_pkg::SLOTS_DEF,
	parameter int TIME_BITS = tet_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  slot,
	input  logic [31:0] wait_ms,
	input  logic        repeat_req,
	input  logic        restart,
	input  logic [47:0] now_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic        last
);

	import tet_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: walks request / scan / flush phases, waits on the output register.
	tet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: live/cancel flags in flops, trigger time, wait and recurring flag
	// in RAMs, one saturating adder, a one-deep holding slot for the newest firing
	// so the final result of a tick can carry last, and the output register.
	tet_dp #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.slot       (slot),
		.wait_ms    (wait_ms),
		.repeat_req (repeat_req),
		.restart    (restart),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot_out   (slot_out),
		.last       (last)
	);

	// an accepted request leaves the block busy in the cycle after the transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request transfer did not make the block busy");

	// controller issues at most one command per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.eval, cmd.flush}))
		else $error("conflicting datapath commands");

	// results are only written into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.flush || (cmd.eval && sts.need_out)) |-> sts.out_free)
		else $error("result pushed into a full output register");

	// after the final tick result the block returns to accepting requests
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !in_stall)
		else $error("block stayed busy after tick flush");

endmodule

>>> hdl/tet_ram.sv
module tet_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tet_ctrl.sv
module tet_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tet_pkg::sts_t sts,
	output tet_pkg::cmd_t cmd
);

	import tet_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_tick ? S_PRIME : S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_PRIME: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.out_free || !sts.need_out) begin
					cmd.eval = 1'b1;
					if (sts.scan_end) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/tet_dp.sv
module tet_dp #(
	parameter int SLOTS     = tet_pkg::SLOTS_DEF,
	parameter int TIME_BITS = tet_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tet_pkg::cmd_t cmd,
	output tet_pkg::sts_t sts,
	input  logic [1:0]    req_type,
	input  logic [3:0]    slot,
	input  logic [31:0]   wait_ms,
	input  logic          repeat_req,
	input  logic          restart,
	input  logic [47:0]   now_ms,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [3:0]    slot_out,
	output logic          last
);

	import tet_pkg::*;

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [31:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s[SUM_W-1:TIME_BITS] != '0) begin
			sat_add = '1;
		end else begin
			sat_add = s[TIME_BITS-1:0];
		end
	endfunction

	// captured request
	req_t                 req_q;
	logic [3:0]           tgt_q;
	logic [31:0]          wait_q;
	logic                 rep_q;
	logic                 rst_q;
	logic [TIME_BITS-1:0] now_q;

	logic [SLOTS-1:0] live_q;
	logic [SLOTS-1:0] dropped_q;
	logic [IW-1:0]    idx_q;
	logic             pend_q;
	logic [IW-1:0]    pend_slot_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [3:0]       slot_out_q;
	logic             last_q;

	// RAM hookup
	logic [IW-1:0]        rd_addr;
	logic [TIME_BITS-1:0] ft_rd, ft_wd;
	logic [31:0]          per_rd;
	logic                 perd_rd;
	logic                 ft_we, per_we, perd_we;
	logic [IW-1:0]        ft_wa, per_wa;

	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] tgt_i;
	logic          tgt_ok;
	logic          scan_end;
	logic          fire;
	logic          out_free;
	logic          push;
	status_t       push_status;
	logic [3:0]    push_slot;
	logic          push_last;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign tgt_i    = IW'(tgt_q);
	assign tgt_ok   = (32'(tgt_q) < SLOTS) && live_q[tgt_i];
	assign scan_end = (idx_q == IW'(SLOTS - 1));
	assign fire     = live_q[idx_q] && !dropped_q[idx_q] && (now_q >= ft_rd);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.is_tick  = (req_t'(req_type) == REQ_TICK);
	assign sts.out_free = out_free;
	assign sts.need_out = fire && pend_q;
	assign sts.scan_end = scan_end;

	// keep the read on the current slot unless it is being retired
	assign rd_addr = (cmd.eval && !scan_end) ? idx_q + IW'(1) : idx_q;

	// one saturating adder serves all trigger-time updates
	assign ft_wd = sat_add(now_q, (req_q == REQ_TICK) ? per_rd : wait_q);

	always_comb begin
		ft_we   = 1'b0;
		ft_wa   = idx_q;
		per_we  = 1'b0;
		per_wa  = free_idx;
		perd_we = 1'b0;
		if (cmd.exec) begin
			if (req_q == REQ_SCHED && free_found) begin
				ft_we   = 1'b1;
				ft_wa   = free_idx;
				per_we  = 1'b1;
				perd_we = 1'b1;
			end else if (req_q == REQ_SETWAIT && tgt_ok) begin
				ft_we  = rst_q;
				ft_wa  = tgt_i;
				per_we = 1'b1;
				per_wa = tgt_i;
			end
		end else if (cmd.eval) begin
			ft_we = fire && perd_rd;
		end
	end

	always_comb begin
		push        = 1'b0;
		push_status = ST_ACCEPTED;
		push_slot   = '0;
		push_last   = 1'b1;
		if (cmd.exec) begin
			push = 1'b1;
			unique case (req_q) inside
				REQ_SCHED: begin
					push_status = free_found ? ST_SCHEDULED : ST_FULL;
					push_slot   = free_found ? 4'(free_idx) : 4'd0;
				end
				REQ_CANCEL, REQ_SETWAIT: begin
					push_status = tgt_ok ? ST_ACCEPTED : ST_NOT_LIVE;
				end
				default: begin
					push_status = ST_IDLE_TICK;
				end
			endcase
		end else if (cmd.eval) begin
			push        = fire && pend_q;
			push_status = ST_FIRED;
			push_slot   = 4'(pend_slot_q);
			push_last   = 1'b0;
		end else if (cmd.flush) begin
			push        = 1'b1;
			push_status = pend_q ? ST_FIRED : ST_IDLE_TICK;
			push_slot   = pend_q ? 4'(pend_slot_q) : 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_t'(req_type);
			tgt_q  <= slot;
			wait_q <= wait_ms;
			rep_q  <= repeat_req;
			rst_q  <= restart;
			now_q  <= TIME_BITS'(now_ms);
		end
		if (cmd.eval && fire) begin
			pend_slot_q <= idx_q;
		end
		if (push) begin
			status_q   <= push_status;
			slot_out_q <= push_slot;
			last_q     <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			dropped_q   <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end
			if (cmd.exec) begin
				if (req_q == REQ_SCHED && free_found) begin
					live_q[free_idx]    <= 1'b1;
					dropped_q[free_idx] <= 1'b0;
				end else if (req_q == REQ_CANCEL && tgt_ok) begin
					dropped_q[tgt_i] <= 1'b1;
				end
			end
			if (cmd.eval) begin
				if (fire) begin
					pend_q <= 1'b1;
					if (!perd_rd) begin
						live_q[idx_q] <= 1'b0;
					end
				end else if (dropped_q[idx_q]) begin
					live_q[idx_q] <= 1'b0;
				end
				if (!scan_end) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (cmd.flush) begin
				pend_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	tet_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_ft_ram (
		.clk   (clk),
		.we    (ft_we),
		.waddr (ft_wa),
		.wdata (ft_wd),
		.raddr (rd_addr),
		.rdata (ft_rd)
	);

	tet_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (per_wa),
		.wdata (wait_q),
		.raddr (rd_addr),
		.rdata (per_rd)
	);

	tet_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_perd_ram (
		.clk   (clk),
		.we    (perd_we),
		.waddr (free_idx),
		.wdata (rep_q),
		.raddr (rd_addr),
		.rdata (perd_rd)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot_out  = slot_out_q;
	assign last      = last_q;

endmodule

>>> bench/tb_timed_event_table_core.sv
module tb_timed_event_table_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tet_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam logic [47:0] TIME_MAX = '1;
	// worst case is roughly 500 requests, each with a busy tick, 16 results behind long
	// stalls and the longest gap; this limit lies well above that
	localparam int CYCLE_LIMIT = 800000;
	// long enough for a tick to scan every slot and flush
	localparam int DRAIN_CYCLES = SLOTS + 8;

	// one request waiting for the driver; hold marks a pause until the table drains
	typedef struct {
		req_t        kind;
		logic [3:0]  tgt;
		logic [31:0] wait_v;
		logic        rep;
		logic        rst;
		logic [47:0] stamp;
		int unsigned gap;
		bit          hold;
	} timer_req_t;

	// one result as it should leave the block
	typedef struct packed {
		status_t    code;
		logic [3:0] slot_no;
		logic       fin;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_TICK;
	logic [3:0]  slot = '0;
	logic [31:0] wait_ms = '0;
	logic        repeat_req = 1'b0;
	logic        restart = 1'b0;
	logic [47:0] now_ms = '0;

	// result channel
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic        last;

	// shadow copy of the slot table
	bit          slot_live     [SLOTS];
	bit          slot_dropped  [SLOTS];
	bit          slot_periodic [SLOTS];
	logic [47:0] slot_fire     [SLOTS];
	logic [31:0] slot_period   [SLOTS];

	timer_req_t request_backlog[$];
	reply_t     expected_replies[$];

	bit          in_took = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int          cycle_count = 0;
	int          fault_count = 0;
	int          checked = 0;
	int          n_sched = 0, n_full = 0, n_cancel = 0, n_setwait = 0, n_tick = 0;
	int          n_fired = 0, peak_burst = 0;

	timed_event_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.slot      (slot),
		.wait_ms   (wait_ms),
		.repeat_req(repeat_req),
		.restart   (restart),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.slot_out  (slot_out),
		.last      (last)
	);

	always #10 clk = ~clk;

	// trigger time = now + wait, pinned at the time maximum on carry-out
	function automatic logic [47:0] sat_sum(input logic [47:0] base, input logic [31:0] w);
		logic [48:0] s;
		s = {1'b0, base} + {17'd0, w};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

	// apply one accepted request to the shadow table and queue its results
	task automatic advance_timer_table(input req_t kind, input logic [3:0] tgt,
			input logic [31:0] w, input logic rep, input logic rst, input logic [47:0] t);
		reply_t burst[$];
		bit     placed;
		int     i;
		placed = 0;
		case (kind) inside
		REQ_SCHED: begin
			n_sched++;
			// lowest free slot wins
			for (i = 0; i < SLOTS; i++) begin
				if (!placed && !slot_live[i]) begin
					placed = 1;
					slot_live[i] = 1;
					slot_dropped[i] = 0;
					slot_periodic[i] = rep;
					slot_period[i] = w;
					slot_fire[i] = sat_sum(t, w);
					burst.push_back('{ST_SCHEDULED, 4'(i), 1'b1});
				end
			end
			if (!placed) begin
				n_full++;
				burst.push_back('{ST_FULL, 4'd0, 1'b1});
			end
		end
		REQ_CANCEL, REQ_SETWAIT: begin
			if (kind == REQ_CANCEL)
				n_cancel++;
			else
				n_setwait++;
			if (!slot_live[tgt]) begin
				burst.push_back('{ST_NOT_LIVE, 4'd0, 1'b1});
			end else begin
				// a dropped slot still takes both requests
				if (kind == REQ_CANCEL) begin
					slot_dropped[tgt] = 1;
				end else begin
					slot_period[tgt] = w;
					if (rst)
						slot_fire[tgt] = sat_sum(t, w);
				end
				burst.push_back('{ST_ACCEPTED, 4'd0, 1'b1});
			end
		end
		default: begin
			n_tick++;
			// scan in slot order; dropped slots are freed whether or not anything fires
			for (i = 0; i < SLOTS; i++) begin
				if (slot_live[i]) begin
					if (!slot_dropped[i] && t >= slot_fire[i]) begin
						burst.push_back('{ST_FIRED, 4'(i), 1'b0});
						if (slot_periodic[i])
							slot_fire[i] = sat_sum(t, slot_period[i]);
						else
							slot_live[i] = 0;
					end else if (slot_dropped[i]) begin
						slot_live[i] = 0;
					end
				end
			end
			if (burst.size() == 0) begin
				burst.push_back('{ST_IDLE_TICK, 4'd0, 1'b1});
			end else begin
				n_fired += burst.size();
				if (burst.size() > peak_burst)
					peak_burst = burst.size();
				burst[burst.size() - 1].fin = 1'b1;
			end
		end
		endcase
		foreach (burst[j])
			expected_replies.push_back(burst[j]);
	endtask

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t ns: %s", $realtime, what);
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// mostly short waits so that ticks catch up with them
	function automatic logic [31:0] pick_wait();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 40);
		if (r < 85)
			return $urandom_range(0, 3);
		if (r < 95)
			return $urandom;
		return 32'hFFFF_FFF0 + $urandom_range(0, 15);
	endfunction

	// low slots are the ones most likely to be live
	function automatic logic [3:0] pick_slot();
		if ($urandom_range(0, 3) == 0)
			return 4'($urandom);
		return 4'($urandom_range(0, 7));
	endfunction

	task automatic push_req(input req_t kind, input logic [3:0] tgt, input logic [31:0] w,
			input logic rep, input logic rst, input logic [47:0] t, input int unsigned g);
		timer_req_t item;
		item = '{kind, tgt, w, rep, rst, t, g, 1'b0};
		request_backlog.push_back(item);
	endtask

	task automatic push_hold();
		timer_req_t item;
		item = '{REQ_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 48'd0, 0, 1'b1};
		request_backlog.push_back(item);
	endtask

	// cancel everything, then a tick that frees the dropped slots
	task automatic push_sweep(input logic [47:0] t);
		int i;
		for (i = 0; i < SLOTS; i++)
			push_req(REQ_CANCEL, 4'(i), $urandom, 1'($urandom), 1'($urandom), t, gap_len());
		push_req(REQ_TICK, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), t, gap_len());
	endtask

	// Request driver: changes inputs on the falling edge only. A payload stays put
	// until the transfer happens; after it, the item's gap is spent with valid low.
	always @(negedge clk) begin
		timer_req_t nxt;
		logic       offer;
		offer = in_valid && !in_took;
		if (arst_n && !offer) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (request_backlog.size() != 0 && request_backlog[0].hold) begin
				// hold the sender back until every outstanding result has been seen
				if (expected_replies.size() == 0)
					void'(request_backlog.pop_front());
			end else if (request_backlog.size() != 0) begin
				nxt = request_backlog.pop_front();
				gap_left = nxt.gap;
				offer = 1'b1;
				req_type <= nxt.kind;
				slot <= nxt.tgt;
				wait_ms <= nxt.wait_v;
				repeat_req <= nxt.rep;
				restart <= nxt.rst;
				now_ms <= nxt.stamp;
			end
			in_valid <= offer;
		end
	end

	// Result back-pressure: random free runs and stall runs, most stalls short.
	always @(negedge clk) begin
		int unsigned r;
		if (stall_left != 0) begin
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(0, 29);
			end else if (r < 90) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(7, 19);
			end
		end
	end

	// Monitor: on the rising edge, check any result transfer against the oldest
	// expectation, then feed any request transfer to the shadow table.
	always @(posedge clk) begin
		reply_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					note_fault($sformatf("unexpected result: status=%0d slot=%0d last=%0d",
						status, slot_out, last));
				end else begin
					want = expected_replies.pop_front();
					checked++;
					if (status !== want.code || slot_out !== want.slot_no || last !== want.fin)
						note_fault($sformatf({"result %0d: expected status=%0d slot=%0d last=%0d,",
							" got status=%0d slot=%0d last=%0d"}, checked, want.code,
							want.slot_no, want.fin, status, slot_out, last));
				end
			end
			if (in_valid && !in_stall)
				advance_timer_table(req_t'(req_type), slot, wait_ms, repeat_req, restart, now_ms);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped at %0d cycles, %0d requests unsent, %0d results outstanding",
				cycle_count, request_backlog.size(), expected_replies.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int          i, k, n_ops, n_rand, next_sweep;
		int unsigned g, r;
		bit          steady;
		logic [47:0] epoch, step;

		// Directed opener: empty-table tick, requests on dead slots, fill the table
		// (zero wait, largest wait, saturating trigger), overflow it, double cancel,
		// wait change on a dropped slot, then a tick at the time maximum that fires
		// nearly every slot.
		push_req(REQ_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 48'd0, gap_len());
		push_req(REQ_CANCEL, 4'd5, 32'd0, 1'b0, 1'b0, 48'd0, gap_len());
		push_req(REQ_SETWAIT, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 48'd0, gap_len());
		for (i = 0; i < SLOTS; i++) begin
			case (i)
			0: push_req(REQ_SCHED, 4'd0, 32'd0, 1'b0, 1'b0, 48'd1000, gap_len());
			1: push_req(REQ_SCHED, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 48'd1000, gap_len());
			2: push_req(REQ_SCHED, 4'd0, 32'd10, 1'b1, 1'b0, TIME_MAX - 48'd5, gap_len());
			default: push_req(REQ_SCHED, 4'(i), 32'(i), 1'(i), 1'b1, 48'd1000, gap_len());
			endcase
		end
		push_req(REQ_SCHED, 4'd9, 32'd1, 1'b1, 1'b1, 48'd1500, gap_len());
		push_req(REQ_CANCEL, 4'd4, 32'd0, 1'b0, 1'b0, 48'd2000, gap_len());
		push_req(REQ_CANCEL, 4'd4, 32'd0, 1'b0, 1'b0, 48'd2000, gap_len());
		push_req(REQ_SETWAIT, 4'd4, 32'd1, 1'b0, 1'b1, 48'd2000, gap_len());
		push_req(REQ_SETWAIT, 4'd6, 32'd0, 1'b0, 1'b0, 48'd2000, gap_len());
		push_req(REQ_TICK, 4'd0, 32'd0, 1'b0, 1'b0, TIME_MAX, gap_len());
		push_hold();
		push_sweep(48'd3000);
		push_hold();

		// Random part: short episodes of well-formed traffic around a moving time
		// base, salted with fully random requests. Some episodes run back to back.
		n_rand = 0;
		next_sweep = 150;
		epoch = 48'd5000;
		while (n_rand < 430) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 19) == 0)
				epoch = TIME_MAX - 48'($urandom_range(0, 200));
			else if (epoch[47:40] != 0 && $urandom_range(0, 2) == 0)
				epoch = 48'($urandom_range(0, 5000));
			n_ops = $urandom_range(3, 12);
			for (k = 0; k < n_ops; k++) begin
				g = steady ? 0 : gap_len();
				r = $urandom_range(0, 99);
				if (r < 10) begin
					push_req(req_t'($urandom_range(0, 3)), 4'($urandom), $urandom,
						1'($urandom), 1'($urandom), {16'($urandom), 32'($urandom)}, g);
				end else if (r < 38) begin
					push_req(REQ_SCHED, 4'($urandom), pick_wait(), 1'($urandom), 1'($urandom),
						epoch, g);
				end else if (r < 50) begin
					push_req(REQ_CANCEL, pick_slot(), $urandom, 1'($urandom), 1'($urandom),
						epoch, g);
				end else if (r < 62) begin
					push_req(REQ_SETWAIT, pick_slot(), pick_wait(), 1'($urandom), 1'($urandom),
						epoch, g);
				end else begin
					step = 48'($urandom_range(0, 30));
					epoch = (TIME_MAX - epoch < step) ? TIME_MAX : epoch + step;
					push_req(REQ_TICK, 4'($urandom), $urandom, 1'($urandom), 1'($urandom),
						epoch, g);
				end
			end
			n_rand += n_ops;
			if (n_rand >= next_sweep) begin
				// let the table drain, then clear it so long waits do not pile up
				push_hold();
				push_sweep(epoch);
				n_rand += SLOTS + 1;
				next_sweep += 150;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_backlog.size() != 0 || in_valid || expected_replies.size() != 0)
			@(negedge clk);
		// a stray result would show up within one tick's time
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_replies.size() != 0)
			note_fault($sformatf("%0d expected results never arrived", expected_replies.size()));

		$display({"requests: %0d schedules (%0d on a full table), %0d cancels,",
			" %0d wait changes, %0d ticks"}, n_sched, n_full, n_cancel, n_setwait, n_tick);
		$display("results checked: %0d, slot firings: %0d, most firings in one tick: %0d",
			checked, n_fired, peak_burst);
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", fault_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/tet_pkg.sv
hdl/tet_ram.sv
hdl/tet_ctrl.sv
hdl/tet_dp.sv
hdl/timed_event_table_core.sv
bench/tb_timed_event_table_core.sv
